// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the controller module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a property holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`endif

// ===== rtl/core/fssm_pkg.sv =====
// Shared types, constants and tables for the Fibonacci search block.
package fssm_pkg;

  localparam int unsigned MaxFib      = 40;
  localparam int unsigned FracBits    = 28;
  localparam int unsigned CordicSteps = 24;

  localparam logic signed [35:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [35:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [35:0] CordicGain = 36'sd652032874;

  typedef enum logic [3:0] {
    StIdle, StSearch, StFirstL, StProbeL, StProbeM, StSinL, StSinM, StDecide, StDone
  } state_e;

  typedef enum logic [2:0] {
    OpNone, OpLoad, OpFibTest, OpDivL, OpDivM, OpSinL, OpSinM, OpStep
  } op_e;

  typedef struct packed {
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic found;
    logic no_search;
    logic last;
    logic lower;
  } status_t;

  function automatic logic [30:0] fib_at(input logic [5:0] k);
    logic [30:0] f [0:46];
    f = '{31'd0, 31'd1, 31'd1, 31'd2, 31'd3, 31'd5, 31'd8, 31'd13, 31'd21, 31'd34,
          31'd55, 31'd89, 31'd144, 31'd233, 31'd377, 31'd610, 31'd987, 31'd1597,
          31'd2584, 31'd4181, 31'd6765, 31'd10946, 31'd17711, 31'd28657,
          31'd46368, 31'd75025, 31'd121393, 31'd196418, 31'd317811, 31'd514229,
          31'd832040, 31'd1346269, 31'd2178309, 31'd3524578, 31'd5702887,
          31'd9227465, 31'd14930352, 31'd24157817, 31'd39088169, 31'd63245986,
          31'd102334155, 31'd165580141, 31'd267914296, 31'd433494437,
          31'd701408733, 31'd1134903170, 31'd1836311903};
    if (k > 6'd46) return '0;
    return f[k];
  endfunction

  function automatic logic [29:0] atan_at(input logic [4:0] j);
    logic [29:0] t [0:31];
    t = '{30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
          30'd67021686, 30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282,
          30'd2097149, 30'd1048575, 30'd524287, 30'd262143, 30'd131071,
          30'd65535, 30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
          30'd1023, 30'd511, 30'd255, 30'd127, 30'd63, 30'd31, 30'd15, 30'd7,
          30'd3, 30'd1, 30'd0, 30'd0};
    return t[j];
  endfunction

endpackage

// ===== rtl/core/fssm_ctrl.sv =====
// Controller state machine that sequences the Fibonacci search.
module fssm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fssm_pkg::status_t status_i,
  output fssm_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  `include "assert_macros.svh"

  fssm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= fssm_pkg::StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fssm_pkg::StIdle:   if (start_i) state_d = fssm_pkg::StSearch;
      fssm_pkg::StSearch: if (status_i.found) begin
        state_d = status_i.no_search ? fssm_pkg::StDone : fssm_pkg::StFirstL;
      end
      fssm_pkg::StFirstL: if (status_i.unit_done) state_d = fssm_pkg::StProbeM;
      fssm_pkg::StProbeL, fssm_pkg::StProbeM: if (status_i.unit_done) begin
        state_d = status_i.last ? fssm_pkg::StDone : fssm_pkg::StSinL;
      end
      fssm_pkg::StSinL:   if (status_i.unit_done) state_d = fssm_pkg::StSinM;
      fssm_pkg::StSinM:   if (status_i.unit_done) state_d = fssm_pkg::StDecide;
      fssm_pkg::StDecide: begin
        state_d = status_i.lower ? fssm_pkg::StProbeL : fssm_pkg::StProbeM;
      end
      fssm_pkg::StDone:   state_d = fssm_pkg::StIdle;
      default:            state_d = fssm_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o.op = fssm_pkg::OpNone;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      fssm_pkg::StIdle: begin
        busy_o = 1'b0;
        if (start_i) cmd_o.op = fssm_pkg::OpLoad;
      end
      fssm_pkg::StSearch: cmd_o.op = fssm_pkg::OpFibTest;
      fssm_pkg::StFirstL, fssm_pkg::StProbeL: cmd_o.op = fssm_pkg::OpDivL;
      fssm_pkg::StProbeM: cmd_o.op = fssm_pkg::OpDivM;
      fssm_pkg::StSinL:   cmd_o.op = fssm_pkg::OpSinL;
      fssm_pkg::StSinM:   cmd_o.op = fssm_pkg::OpSinM;
      fssm_pkg::StDecide: cmd_o.op = fssm_pkg::OpStep;
      fssm_pkg::StDone:   done_o = 1'b1;
      default:            busy_o = 1'b1;
    endcase
  end

  `ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ASSERT_CLK(a_done_busy, clk_i, rst_ni, !done_o || busy_o)
endmodule

// ===== rtl/core/fssm_dp.sv =====
// Datapath with interval registers, a serial divider and a serial CORDIC unit.
module fssm_dp #(
  parameter int unsigned MaxFib      = fssm_pkg::MaxFib,
  parameter int unsigned CordicSteps = fssm_pkg::CordicSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fssm_pkg::cmd_t     cmd_i,
  input  logic signed [31:0] end_a_i,
  input  logic signed [31:0] end_b_i,
  input  logic [30:0]        tolerance_i,
  output fssm_pkg::status_t  status_o,
  output logic signed [31:0] minimizer_o,
  output logic [5:0]         fib_index_o,
  output logic               index_saturated_o
);
  localparam logic [5:0] MaxFibW = 6'(MaxFib);
  localparam logic [5:0] StepsW  = 6'(CordicSteps);
  localparam int unsigned QShift = 30 - fssm_pkg::FracBits;

  logic signed [32:0] a_q, a_d, b_q, b_d, l_q, l_d, m_q, m_d;
  logic [30:0] tol_q;
  logic [5:0]  i_q, i_d, k_q, k_d;
  logic        sat_q, sat_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [62:0] rem_q, rem_d;
  logic [62:0] num_q, num_d;
  logic [31:0] quo_q, quo_d;
  logic signed [37:0] cx_q, cx_d, cy_q, cy_d, t_q, t_d;
  logic signed [37:0] sl_q, sl_d;

  logic [31:0] width;
  logic [61:0] prod;
  logic [32:0] dmag;
  logic        dneg;
  logic [5:0]  numk;
  logic [30:0] den;
  logic signed [32:0] base;
  logic signed [37:0] ang, red, dx, dy;
  logic [63:0] trial;
  logic signed [32:0] probe;

  always_comb begin
    width = (a_q >= b_q) ? 32'(a_q - b_q) : 32'(b_q - a_q);
    prod = 62'(tol_q) * 62'(fssm_pkg::fib_at(i_q));
    base = a_q;
    dmag = (b_q >= a_q) ? 33'(b_q - a_q) : 33'(a_q - b_q);
    dneg = b_q < a_q;
    numk = (cmd_i.op == fssm_pkg::OpDivL) ? k_q - 6'd2 : k_q - 6'd1;
    den  = fssm_pkg::fib_at(k_q);
    trial = {rem_q, num_q[62]} - {33'd0, den};
    probe = dneg ? base - 33'(quo_q) : base + 33'(quo_q);
    ang = 38'((cmd_i.op == fssm_pkg::OpSinL ? l_q : m_q)) <<< QShift;
    red = ang;
    if (ang >= fssm_pkg::Q30TwoPi) red = ang - fssm_pkg::Q30TwoPi;
    else if (ang <= -fssm_pkg::Q30TwoPi) red = ang + fssm_pkg::Q30TwoPi;
    if (red > fssm_pkg::Q30Pi) red = red - fssm_pkg::Q30TwoPi;
    if (red < -fssm_pkg::Q30Pi) red = red + fssm_pkg::Q30TwoPi;
    if (red > fssm_pkg::Q30HalfPi) red = fssm_pkg::Q30Pi - red;
    if (red < -fssm_pkg::Q30HalfPi) red = -fssm_pkg::Q30Pi - red;
    dx = cy_q >>> cnt_q[4:0];
    dy = cx_q >>> cnt_q[4:0];
  end

  always_comb begin
    a_d = a_q; b_d = b_q; l_d = l_q; m_d = m_q; i_d = i_q; k_d = k_q;
    sat_d = sat_q; cnt_d = cnt_q; run_d = run_q; rem_d = rem_q; num_d = num_q;
    quo_d = quo_q; cx_d = cx_q; cy_d = cy_q; t_d = t_q; sl_d = sl_q;
    status_o = '0;
    case (cmd_i.op)
      fssm_pkg::OpLoad: begin
        a_d = 33'(end_a_i); b_d = 33'(end_b_i);
        i_d = 6'd1; sat_d = 1'b0; run_d = 1'b0;
      end
      fssm_pkg::OpFibTest: begin
        if ({30'd0, width} <= prod) begin
          status_o.found = 1'b1;
          status_o.no_search = i_q < 6'd3;
          k_d = i_q;
        end else if (i_q == MaxFibW) begin
          status_o.found = 1'b1;
          sat_d = 1'b1;
          status_o.no_search = i_q < 6'd3;
          k_d = i_q;
        end else begin
          i_d = i_q + 6'd1;
        end
      end
      fssm_pkg::OpDivL, fssm_pkg::OpDivM: begin
        if (!run_q) begin
          run_d = 1'b1; cnt_d = '0; rem_d = '0; quo_d = '0;
          num_d = 63'(fssm_pkg::fib_at(numk)) * 63'(dmag);
        end else if (cnt_q != 6'd63) begin
          if (!trial[63]) begin
            rem_d = trial[62:0];
            if (cnt_q >= 6'd31) quo_d = {quo_q[30:0], 1'b1};
          end else begin
            rem_d = {rem_q[61:0], num_q[62]};
            if (cnt_q >= 6'd31) quo_d = {quo_q[30:0], 1'b0};
          end
          num_d = {num_q[61:0], 1'b0};
          cnt_d = cnt_q + 6'd1;
        end else begin
          run_d = 1'b0;
          status_o.unit_done = 1'b1;
          status_o.last = k_q < 6'd3;
          if (cmd_i.op == fssm_pkg::OpDivL) l_d = probe;
          else m_d = probe;
        end
      end
      fssm_pkg::OpSinL, fssm_pkg::OpSinM: begin
        if (!run_q) begin
          run_d = 1'b1; cnt_d = '0; t_d = red;
          cx_d = 38'(fssm_pkg::CordicGain); cy_d = '0;
        end else if (cnt_q != StepsW) begin
          if (t_q >= 0) begin
            cx_d = cx_q - dx; cy_d = cy_q + dy;
            t_d = t_q - 38'(fssm_pkg::atan_at(cnt_q[4:0]));
          end else begin
            cx_d = cx_q + dx; cy_d = cy_q - dy;
            t_d = t_q + 38'(fssm_pkg::atan_at(cnt_q[4:0]));
          end
          cnt_d = cnt_q + 6'd1;
        end else begin
          run_d = 1'b0;
          status_o.unit_done = 1'b1;
          if (cmd_i.op == fssm_pkg::OpSinL) sl_d = cy_q;
        end
      end
      fssm_pkg::OpStep: begin
        status_o.lower = sl_q < cy_q;
        if (sl_q < cy_q) begin
          b_d = m_q; m_d = l_q;
        end else begin
          a_d = l_q; l_d = m_q;
        end
        k_d = k_q - 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; l_q <= l_d; m_q <= m_d; i_q <= i_d; k_q <= k_d;
    sat_q <= sat_d; cnt_q <= cnt_d; rem_q <= rem_d; num_q <= num_d;
    quo_q <= quo_d; cx_q <= cx_d; cy_q <= cy_d; t_q <= t_d; sl_q <= sl_d;
    if (cmd_i.op == fssm_pkg::OpLoad) tol_q <= tolerance_i;
  end

  logic signed [33:0] sum;
  assign sum = 34'(a_q) + 34'(b_q);
  assign minimizer_o = 32'(sum >>> 1);
  assign fib_index_o = i_q;
  assign index_saturated_o = sat_q;
endmodule

// ===== rtl/core/fibonacci_search_sine_minimum.sv =====
// Top level: Fibonacci search for the minimum of sine over an interval.
// For an index below 3 no probe points are computed.
// The serial 63-step divider and the serial CORDIC unit handle one item at a time; the next
// transfer is accepted in the cycle after done_o, which pulses once and cannot stall.
// Reset is asynchronous and active low; it returns the block to idle.
module fibonacci_search_sine_minimum #(
  parameter int unsigned MaxFib      = fssm_pkg::MaxFib,
  parameter int unsigned CordicSteps = fssm_pkg::CordicSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] end_a_i,
  input  logic signed [31:0] end_b_i,
  input  logic [30:0]        tolerance_i,
  output logic               done_o,
  output logic signed [31:0] minimizer_o,
  output logic [5:0]         fib_index_o,
  output logic               index_saturated_o
);
  fssm_pkg::cmd_t    cmd;
  fssm_pkg::status_t status;

  fssm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .status_i(status), .cmd_o(cmd),
    .busy_o(busy), .done_o
  );

  fssm_dp #(.MaxFib(MaxFib), .CordicSteps(CordicSteps)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .end_a_i, .end_b_i, .tolerance_i,
    .status_o(status), .minimizer_o, .fib_index_o, .index_saturated_o
  );
endmodule

// ===== tb/fibonacci_search_sine_minimum_tb.sv =====
// Testbench for the Fibonacci search sine minimum block: directed table, then random transfers.
`timescale 1ns / 100ps

module fibonacci_search_sine_minimum_tb;

  typedef struct {
    logic signed [31:0] minimizer;
    logic [5:0]         fib_index;
    logic               saturated;
  } search_result_t;

  typedef struct {
    logic signed [31:0] end_a;
    logic signed [31:0] end_b;
    logic [30:0]        tol;
    bit                 typed;
    search_result_t     want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] end_a_i = '0;
  logic signed [31:0] end_b_i = '0;
  logic [30:0]        tolerance_i = 31'd1;
  logic               done_o;
  logic signed [31:0] minimizer_o;
  logic [5:0]         fib_index_o;
  logic               index_saturated_o;

  search_result_t pending_minima[$];
  int unsigned    mismatches = 0;
  longint         fib_seq[0:46];
  longint         atan_q30[0:31] = '{843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127,
    63, 31, 15, 7, 3, 1, 0, 0};

  fibonacci_search_sine_minimum dut (
    .clk_i, .rst_ni, .start, .busy, .end_a_i, .end_b_i, .tolerance_i,
    .done_o, .minimizer_o, .fib_index_o, .index_saturated_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 3000000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint sine_of(input longint x);
    longint t, cx, cy, dx, dy;
    t = x * (longint'(1) << (30 - fssm_pkg::FracBits));
    cx = fssm_pkg::CordicGain;
    cy = 0;
    t = t % longint'(fssm_pkg::Q30TwoPi);
    if (t > fssm_pkg::Q30Pi) t -= fssm_pkg::Q30TwoPi;
    if (t < -fssm_pkg::Q30Pi) t += fssm_pkg::Q30TwoPi;
    if (t > fssm_pkg::Q30HalfPi) t = fssm_pkg::Q30Pi - t;
    if (t < -fssm_pkg::Q30HalfPi) t = -fssm_pkg::Q30Pi - t;
    for (int j = 0; j < fssm_pkg::CordicSteps; j++) begin
      dx = cy >>> (j & 31);
      dy = cx >>> (j & 31);
      if (t >= 0) begin
        cx -= dx; cy += dy; t -= atan_q30[j & 31];
      end else begin
        cx += dx; cy -= dy; t += atan_q30[j & 31];
      end
    end
    return cy;
  endfunction

  function automatic longint probe_point(input longint a, input longint b, input int num,
                                         input int den);
    longint d, mag, q;
    d = b - a;
    mag = (d < 0) ? -d : d;
    q = (fib_seq[num] * mag) / fib_seq[den];
    return (d < 0) ? a - q : a + q;
  endfunction

  function automatic search_result_t search_minimum(input logic signed [31:0] ea,
                                                   input logic signed [31:0] eb,
                                                   input logic [30:0] tol);
    search_result_t r;
    longint a, b, l, m, width, s;
    int idx;
    bit sat;
    a = ea;
    b = eb;
    width = (a > b) ? a - b : b - a;
    sat = 1'b1;
    for (idx = 1; idx <= fssm_pkg::MaxFib; idx++) begin
      if (width <= longint'(tol) * fib_seq[idx]) begin
        sat = 1'b0;
        break;
      end
    end
    if (sat) idx = fssm_pkg::MaxFib;
    if (idx >= 3) begin
      l = probe_point(a, b, idx - 2, idx);
      m = probe_point(a, b, idx - 1, idx);
      for (int k = idx - 1; k >= 2; k--) begin
        if (sine_of(l) < sine_of(m)) begin
          b = m; m = l; l = probe_point(a, b, k - 2, k);
        end else begin
          a = l; l = m; m = probe_point(a, b, k - 1, k);
        end
      end
    end
    s = a + b;
    r.minimizer = 32'((s >= 0) ? s / 2 : -((-s + 1) / 2));
    r.fib_index = 6'(idx);
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk_i) begin
    search_result_t w;
    if (rst_ni && done_o) begin
      if (pending_minima.size() == 0) begin
        $display("%0t: unexpected result minimizer=%0d index=%0d sat=%0b", $time,
                 minimizer_o, fib_index_o, index_saturated_o);
        mismatches++;
      end else begin
        w = pending_minima.pop_front();
        if (minimizer_o !== w.minimizer) begin
          $display("%0t: minimizer expected %0d actual %0d", $time, w.minimizer,
                   minimizer_o);
          mismatches++;
        end
        if (fib_index_o !== w.fib_index) begin
          $display("%0t: fib_index expected %0d actual %0d", $time, w.fib_index,
                   fib_index_o);
          mismatches++;
        end
        if (index_saturated_o !== w.saturated) begin
          $display("%0t: index_saturated expected %0b actual %0b", $time, w.saturated,
                   index_saturated_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_item(input stim_row_t row, input bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
    start <= 1'b1;
    end_a_i <= row.end_a;
    end_b_i <= row.end_b;
    tolerance_i <= row.tol;
    do @(posedge clk_i); while (busy);
    pending_minima.push_back(row.typed ? row.want
                                       : search_minimum(row.end_a, row.end_b, row.tol));
  endtask

  function automatic stim_row_t make_row(input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic [30:0] t);
    stim_row_t r;
    r.end_a = a; r.end_b = b; r.tol = t; r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic [30:0] t,
                                          input logic signed [31:0] mid,
                                          input logic [5:0] idx, input logic sat);
    stim_row_t r;
    r = make_row(a, b, t);
    r.typed = 1'b1;
    r.want.minimizer = mid; r.want.fib_index = idx; r.want.saturated = sat;
    return r;
  endfunction

  initial begin
    stim_row_t directed[$];
    stim_row_t row;
    logic signed [31:0] a, b;
    longint width;

    fib_seq[0] = 0;
    fib_seq[1] = 1;
    for (int n = 2; n <= 46; n++) fib_seq[n] = fib_seq[n-1] + fib_seq[n-2];

    directed.push_back(typed_row(32'sd0, 32'sd0, 31'd1, 32'sd0, 6'd1, 1'b0));
    directed.push_back(typed_row(32'sh80000000, 32'sh80000000, 31'd1,
                                 32'sh80000000, 6'd1, 1'b0));
    directed.push_back(typed_row(32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
                                 32'sh7fffffff, 6'd1, 1'b0));
    directed.push_back(typed_row(32'sd0, 32'sd10, 31'd10, 32'sd5, 6'd1, 1'b0));
    directed.push_back(typed_row(32'sd10, 32'sd0, 31'd10, 32'sd5, 6'd1, 1'b0));
    directed.push_back(typed_row(-32'sd3, 32'sd0, 31'd3, -32'sd2, 6'd1, 1'b0));
    directed.push_back(make_row(32'sh80000000, 32'sh7fffffff, 31'h7fffffff));
    directed.push_back(make_row(32'sh80000000, 32'sh7fffffff, 31'd1));
    directed.push_back(make_row(32'sh7fffffff, 32'sh80000000, 31'd1));
    directed.push_back(make_row(32'sd0, 32'sd1000000000, 31'd3));
    directed.push_back(make_row(-32'sd805306368, 32'sd0, 31'd1000000));
    directed.push_back(make_row(32'sd0, 32'sd268435456, 31'd16777216));
    directed.push_back(make_row(32'sd268435456, -32'sd268435456, 31'd65536));
    directed.push_back(make_row(32'sd843314856, 32'sd1686629713, 31'd4096));
    directed.push_back(make_row(32'sd0, 32'sd21, 31'd1));
    directed.push_back(make_row(32'sd0, 32'sd22, 31'd1));
    directed.push_back(make_row(-32'sd1686629713, -32'sd1, 31'd100000));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n]) send_item(directed[n], 1'b1);

    for (int n = 0; n < 123; n++) begin
      a = $urandom;
      b = $urandom;
      if ($urandom_range(0, 3) == 0) b = a + $signed($urandom_range(0, 65535)) - 32768;
      width = (a > b) ? longint'(a) - b : longint'(b) - a;
      if ($urandom_range(0, 19) == 0) begin
        row = make_row(a, b, 31'($urandom_range(1, 40)));
      end else if ($urandom_range(0, 9) == 0) begin
        row = make_row(a, b, 31'($urandom) | 31'd1);
      end else begin
        row.tol = 31'((width >> $urandom_range(0, 10)) >> 1);
        if (row.tol == 0) row.tol = 31'd1;
        row = make_row(a, b, row.tol);
      end
      if (n == 70) begin
        start <= 1'b0;
        while (pending_minima.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      send_item(row, !(n >= 60 && n < 100));
    end
    start <= 1'b0;

    while (pending_minima.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fssm_pkg.sv
rtl/core/fssm_ctrl.sv
rtl/core/fssm_dp.sv
rtl/core/fibonacci_search_sine_minimum.sv
tb/fibonacci_search_sine_minimum_tb.sv
